FILE: design/olte_pkg.sv
// ----------------------------------------------------------------------------
// olte_pkg
// Shared sizes, command and status codes and the sequencer state type of the
// ordered list table engine.
// ----------------------------------------------------------------------------
package olte_pkg;

    localparam int CAPACITY = 256;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int CMD_W    = 3;
    localparam int POS_W    = 9;
    localparam int VAL_W    = 32;
    localparam int STAT_W   = 3;
    localparam int FIDX_W   = 8;
    localparam int COUNT_W  = 9;

    // width for slot / count compares
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_ERASE      = 3'd5;
    localparam logic [CMD_W-1:0] CMD_FIND       = 3'd6;

    localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd1;
    localparam logic [STAT_W-1:0] STAT_FULL     = 3'd2;
    localparam logic [STAT_W-1:0] STAT_BADPOS   = 3'd3;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT_UP,
        ST_PUT,
        ST_SHIFT_DN,
        ST_FIND,
        ST_DONE
    } state_t;

endpackage

FILE: design/olte_req_if.sv
// ----------------------------------------------------------------------------
// olte_req_if
// Command channel: valid/ready handshake carrying one command item.
// ----------------------------------------------------------------------------
interface olte_req_if
    import olte_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic [POS_W-1:0]         position;
    logic signed [VAL_W-1:0]  value;

    modport source (output valid, output cmd, output position, output value, input ready);
    modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

FILE: design/olte_rsp_if.sv
// ----------------------------------------------------------------------------
// olte_rsp_if
// Result channel: valid/ready handshake carrying one result item.
// ----------------------------------------------------------------------------
interface olte_rsp_if
    import olte_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [STAT_W-1:0]    status;
    logic [FIDX_W-1:0]    found_index;
    logic [COUNT_W-1:0]   count;

    modport source (output valid, output status, output found_index, output count,
                    input ready);
    modport sink   (input valid, input status, input found_index, input count,
                    output ready);
endinterface

FILE: design/ordered_list_table_engine_unit.sv
// ----------------------------------------------------------------------------
// ordered_list_table_engine_unit
// Packed ordered list of signed 32-bit values in one synchronous RAM, with
// push/pop at both ends, positional insert/erase and first-match find.
// ----------------------------------------------------------------------------
// Sequence: push back, pop back, refused commands and tail insert / erase go
//   straight to the result register; insert / push front move the entries
//   from the slot up by one, tail first, then write the value; erase / pop
//   front move later entries down by one; find scans to a match or the end.
// Throughput: one item at a time; the shift and scan loops move one entry per
//   cycle through the single-read, single-write RAM port pair.
// Reset: clears the count, sequencer and result valid; RAM is not cleared.
module ordered_list_table_engine_unit
    import olte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    olte_req_if.sink    req,
    olte_rsp_if.source  rsp
);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [ADDR_W-1:0]   ptr_reg, ptr_next;     // last RAM address read
    logic [ADDR_W-1:0]   lim_reg, lim_next;     // loop end address
    logic [VAL_W-1:0]    val_reg, val_next;     // value to put / search for
    logic [STAT_W-1:0]   res_status_reg, res_status_next;
    logic [ADDR_W-1:0]   res_found_reg, res_found_next;

    logic                rsp_valid_reg, rsp_valid_next;
    logic [STAT_W-1:0]   rsp_status_reg;
    logic [FIDX_W-1:0]   rsp_found_reg;
    logic [COUNT_W-1:0]  rsp_count_reg;

    // RAM ports
    logic [VAL_W-1:0]    mem [CAPACITY];
    logic                rd_en, wr_en;
    logic [ADDR_W-1:0]   rd_addr, wr_addr;
    logic [VAL_W-1:0]    wr_data, rd_data_reg;

    // ------------------------------------------------------------------
    // Handshake and shared conditions
    // ------------------------------------------------------------------
    logic acc;          // command item taken this cycle
    logic out_free;     // result register can take a new item
    logic out_load;
    logic last;         // loop pointer reached its end
    logic hit;          // find compare

    assign req.ready = (state_reg == ST_IDLE);
    assign acc       = req.valid && req.ready;
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign out_load  = (state_reg == ST_DONE) && out_free;
    assign last      = (ptr_reg == lim_reg);
    assign hit       = (rd_data_reg == val_reg);

    // ------------------------------------------------------------------
    // Command decode (valid in idle)
    // ------------------------------------------------------------------
    logic [CMP_W-1:0]   cnt_w, pos_w, slot;
    logic               is_full, is_empty;
    logic               do_ins, do_ers, do_find;
    logic               ins_ok, ers_ok, find_go, ins_direct, ers_direct;
    logic [STAT_W-1:0]  dec_status;
    state_t             dec_go;

    always_comb
    begin
        cnt_w      = CMP_W'(count_reg);
        pos_w      = CMP_W'(req.position);
        is_full    = (count_reg == CNT_W'(CAPACITY));
        is_empty   = (count_reg == '0);
        slot       = '0;
        do_ins     = 1'b0;
        do_ers     = 1'b0;
        do_find    = 1'b0;
        dec_status = STAT_OK;

        unique case (req.cmd)
            CMD_PUSH_BACK:
            begin
                do_ins = 1'b1;
                slot   = cnt_w;
            end
            CMD_PUSH_FRONT:
            begin
                do_ins = 1'b1;
            end
            CMD_INSERT:
            begin
                if (req.position == '0)
                    dec_status = is_full ? STAT_FULL : STAT_BADPOS;
                else
                begin
                    do_ins = 1'b1;
                    slot   = pos_w - CMP_W'(1);
                end
            end
            CMD_POP_BACK:
            begin
                do_ers = 1'b1;
                slot   = cnt_w - CMP_W'(1);
            end
            CMD_POP_FRONT:
            begin
                do_ers = 1'b1;
            end
            CMD_ERASE:
            begin
                if (req.position == '0)
                    dec_status = is_empty ? STAT_EMPTY : STAT_BADPOS;
                else
                begin
                    do_ers = 1'b1;
                    slot   = pos_w - CMP_W'(1);
                end
            end
            CMD_FIND:
            begin
                do_find = 1'b1;
            end
            default: ;  // unused code: no change, status ok
        endcase

        ins_ok  = 1'b0;
        ers_ok  = 1'b0;
        find_go = 1'b0;
        if (do_ins)
        begin
            if (is_full)
                dec_status = STAT_FULL;
            else if (slot > cnt_w)
                dec_status = STAT_BADPOS;
            else
                ins_ok = 1'b1;
        end
        if (do_ers)
        begin
            if (is_empty)
                dec_status = STAT_EMPTY;
            else if (slot >= cnt_w)
                dec_status = STAT_BADPOS;
            else
                ers_ok = 1'b1;
        end
        if (do_find)
        begin
            if (is_empty)
                dec_status = STAT_NOTFOUND;
            else
                find_go = 1'b1;
        end

        // append at the tail / drop the tail: no entries to move
        ins_direct = (slot == cnt_w);
        ers_direct = (slot == cnt_w - CMP_W'(1));

        dec_go = ST_DONE;
        if (ins_ok && !ins_direct)
            dec_go = ST_SHIFT_UP;
        else if (ers_ok && !ers_direct)
            dec_go = ST_SHIFT_DN;
        else if (find_go)
            dec_go = ST_FIND;
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (acc) state_next = dec_go;
            ST_SHIFT_UP: if (last) state_next = ST_PUT;
            ST_PUT:      state_next = ST_DONE;
            ST_SHIFT_DN: if (last) state_next = ST_DONE;
            ST_FIND:     if (hit || last) state_next = ST_DONE;
            ST_DONE:     if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and RAM control
    // ------------------------------------------------------------------
    always_comb
    begin
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        lim_next        = lim_reg;
        val_next        = val_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        rd_en           = 1'b0;
        rd_addr         = ptr_reg;
        wr_en           = 1'b0;
        wr_addr         = ptr_reg;
        wr_data         = rd_data_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    res_status_next = dec_status;
                    res_found_next  = '0;
                    val_next        = req.value;
                    if (ins_ok)
                    begin
                        count_next = count_reg + CNT_W'(1);
                        lim_next   = slot[ADDR_W-1:0];
                        if (ins_direct)
                        begin
                            wr_en   = 1'b1;
                            wr_addr = slot[ADDR_W-1:0];
                            wr_data = req.value;
                        end
                        else
                        begin
                            // move entries up, starting from the tail
                            rd_en    = 1'b1;
                            rd_addr  = ADDR_W'(count_reg - CNT_W'(1));
                            ptr_next = ADDR_W'(count_reg - CNT_W'(1));
                        end
                    end
                    else if (ers_ok)
                    begin
                        count_next = count_reg - CNT_W'(1);
                        lim_next   = ADDR_W'(count_reg - CNT_W'(1));
                        if (!ers_direct)
                        begin
                            rd_en    = 1'b1;
                            rd_addr  = slot[ADDR_W-1:0] + ADDR_W'(1);
                            ptr_next = slot[ADDR_W-1:0] + ADDR_W'(1);
                        end
                    end
                    else if (find_go)
                    begin
                        lim_next = ADDR_W'(count_reg - CNT_W'(1));
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        ptr_next = '0;
                    end
                end
            end
            ST_SHIFT_UP:
            begin
                wr_en   = 1'b1;
                wr_addr = ptr_reg + ADDR_W'(1);
                if (!last)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = ptr_reg - ADDR_W'(1);
                    ptr_next = ptr_reg - ADDR_W'(1);
                end
            end
            ST_PUT:
            begin
                wr_en   = 1'b1;
                wr_addr = lim_reg;
                wr_data = val_reg;
            end
            ST_SHIFT_DN:
            begin
                wr_en   = 1'b1;
                wr_addr = ptr_reg - ADDR_W'(1);
                if (!last)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = ptr_reg + ADDR_W'(1);
                    ptr_next = ptr_reg + ADDR_W'(1);
                end
            end
            ST_FIND:
            begin
                if (hit)
                begin
                    res_status_next = STAT_OK;
                    res_found_next  = ptr_reg;
                end
                else if (last)
                    res_status_next = STAT_NOTFOUND;
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = ptr_reg + ADDR_W'(1);
                    ptr_next = ptr_reg + ADDR_W'(1);
                end
            end
            ST_DONE: ;
            default: ;
        endcase
    end

    // result register: holds one item until taken
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (out_load)
            rsp_valid_next = 1'b1;
        else if (rsp.ready)
            rsp_valid_next = 1'b0;
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        lim_reg        <= lim_next;
        val_reg        <= val_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        if (out_load)
        begin
            rsp_status_reg <= res_status_reg;
            rsp_found_reg  <= FIDX_W'(res_found_reg);
            rsp_count_reg  <= COUNT_W'(count_reg);
        end
    end

    // entry RAM, one read and one write port, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.found_index = rsp_found_reg;
    assign rsp.count       = rsp_count_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_no_rw_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && wr_en) |-> (rd_addr != wr_addr))
        else $error("RAM read and write hit the same entry");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp.ready) |=> !out_load || rsp.ready)
        else $error("pending result overwritten");

    a_find_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIND && hit) |-> (ptr_reg <= lim_reg))
        else $error("find matched beyond the list end");

endmodule
